[rtl/core/mrqe_pkg.sv]
// ----------------------------------------------------------------------------
// mrqe_pkg
// Types, constants, the microcode table and helpers for the rotation
// quaternion extraction core.
// ----------------------------------------------------------------------------
`default_nettype none

package mrqe_pkg;

    localparam int DIV_W     = 60;
    localparam int MEM_DEPTH = 18;
    localparam int S_BASE    = 9;
    localparam int PC_W      = 6;

    typedef logic [4:0] addr_t;

    typedef enum logic [5:0] {
        U_IDLE, U_LOAD, U_START, U_CF_F1, U_MUL, U_CF_L2, U_CF_WR,
        U_DT_F, U_DT_ACC, U_DT_CHK, U_UP_F, U_UP_GO, U_UP_WAIT, U_UP_WR,
        U_UP_ACC, U_IT_END, U_QF_0, U_QF_1, U_QF_2, U_QF_3, U_QF_4, U_QF_5,
        U_QS_GO, U_QS_WAIT, U_QS_ST, U_QS_ACC, U_QN_GO, U_QN_WAIT, U_QN_CHK,
        U_QD_GO, U_QD_WAIT, U_QD_ST, U_OUT
    } uop_t;

    typedef enum logic [2:0] {
        K_NEXT, K_LOOP, K_WAIT_IN, K_WAIT_U, K_BRANCH, K_OUT
    } seq_t;

    typedef struct packed {
        uop_t            uop;
        seq_t            kind;
        logic [3:0]      last;
        logic [PC_W-1:0] tgt;
    } ucw_t;

    typedef struct packed {
        addr_t ra;
        addr_t rb;
    } rd_pair_t;

    function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
        ucw_t cw;
        case (pc)
            6'd0:    cw = '{U_IDLE,    K_WAIT_IN, 4'd0, 6'd0};
            6'd1:    cw = '{U_LOAD,    K_LOOP,    4'd8, 6'd1};
            6'd2:    cw = '{U_START,   K_BRANCH,  4'd0, 6'd19};
            6'd3:    cw = '{U_CF_F1,   K_NEXT,    4'd0, 6'd0};
            6'd4:    cw = '{U_MUL,     K_NEXT,    4'd0, 6'd0};
            6'd5:    cw = '{U_CF_L2,   K_NEXT,    4'd0, 6'd0};
            6'd6:    cw = '{U_MUL,     K_NEXT,    4'd0, 6'd0};
            6'd7:    cw = '{U_CF_WR,   K_LOOP,    4'd8, 6'd3};
            6'd8:    cw = '{U_DT_F,    K_NEXT,    4'd0, 6'd0};
            6'd9:    cw = '{U_MUL,     K_NEXT,    4'd0, 6'd0};
            6'd10:   cw = '{U_DT_ACC,  K_LOOP,    4'd2, 6'd8};
            6'd11:   cw = '{U_DT_CHK,  K_BRANCH,  4'd0, 6'd19};
            6'd12:   cw = '{U_UP_F,    K_NEXT,    4'd0, 6'd0};
            6'd13:   cw = '{U_UP_GO,   K_NEXT,    4'd0, 6'd0};
            6'd14:   cw = '{U_UP_WAIT, K_WAIT_U,  4'd0, 6'd0};
            6'd15:   cw = '{U_UP_WR,   K_NEXT,    4'd0, 6'd0};
            6'd16:   cw = '{U_MUL,     K_NEXT,    4'd0, 6'd0};
            6'd17:   cw = '{U_UP_ACC,  K_LOOP,    4'd8, 6'd12};
            6'd18:   cw = '{U_IT_END,  K_BRANCH,  4'd0, 6'd3};
            6'd19:   cw = '{U_QF_0,    K_NEXT,    4'd0, 6'd0};
            6'd20:   cw = '{U_QF_1,    K_NEXT,    4'd0, 6'd0};
            6'd21:   cw = '{U_QF_2,    K_NEXT,    4'd0, 6'd0};
            6'd22:   cw = '{U_QF_3,    K_NEXT,    4'd0, 6'd0};
            6'd23:   cw = '{U_QF_4,    K_NEXT,    4'd0, 6'd0};
            6'd24:   cw = '{U_QF_5,    K_NEXT,    4'd0, 6'd0};
            6'd25:   cw = '{U_QS_GO,   K_NEXT,    4'd0, 6'd0};
            6'd26:   cw = '{U_QS_WAIT, K_WAIT_U,  4'd0, 6'd0};
            6'd27:   cw = '{U_QS_ST,   K_NEXT,    4'd0, 6'd0};
            6'd28:   cw = '{U_MUL,     K_NEXT,    4'd0, 6'd0};
            6'd29:   cw = '{U_QS_ACC,  K_LOOP,    4'd3, 6'd25};
            6'd30:   cw = '{U_QN_GO,   K_NEXT,    4'd0, 6'd0};
            6'd31:   cw = '{U_QN_WAIT, K_WAIT_U,  4'd0, 6'd0};
            6'd32:   cw = '{U_QN_CHK,  K_BRANCH,  4'd0, 6'd36};
            6'd33:   cw = '{U_QD_GO,   K_NEXT,    4'd0, 6'd0};
            6'd34:   cw = '{U_QD_WAIT, K_WAIT_U,  4'd0, 6'd0};
            6'd35:   cw = '{U_QD_ST,   K_LOOP,    4'd3, 6'd33};
            6'd36:   cw = '{U_OUT,     K_OUT,     4'd0, 6'd0};
            default: cw = '{U_OUT,     K_OUT,     4'd0, 6'd0};
        endcase
        return cw;
    endfunction

    // cofactor operand addresses, first or second product
    function automatic rd_pair_t cof_addr(input logic [3:0] idx, input logic second);
        rd_pair_t p1;
        rd_pair_t p2;
        case (idx)
            4'd0:    begin p1 = '{5'd4, 5'd8}; p2 = '{5'd7, 5'd5}; end
            4'd1:    begin p1 = '{5'd3, 5'd8}; p2 = '{5'd6, 5'd5}; end
            4'd2:    begin p1 = '{5'd3, 5'd7}; p2 = '{5'd6, 5'd4}; end
            4'd3:    begin p1 = '{5'd1, 5'd8}; p2 = '{5'd7, 5'd2}; end
            4'd4:    begin p1 = '{5'd0, 5'd8}; p2 = '{5'd6, 5'd2}; end
            4'd5:    begin p1 = '{5'd0, 5'd7}; p2 = '{5'd6, 5'd1}; end
            4'd6:    begin p1 = '{5'd1, 5'd5}; p2 = '{5'd4, 5'd2}; end
            4'd7:    begin p1 = '{5'd0, 5'd5}; p2 = '{5'd3, 5'd2}; end
            4'd8:    begin p1 = '{5'd0, 5'd4}; p2 = '{5'd3, 5'd1}; end
            default: begin p1 = '{5'd0, 5'd0}; p2 = '{5'd0, 5'd0}; end
        endcase
        return second ? p2 : p1;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/mrqe_div.sv]
// ----------------------------------------------------------------------------
// mrqe_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrqe_div
    import mrqe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] num,
    input  wire logic [DIV_W-1:0] den,
    output logic                  busy,
    output logic [DIV_W-1:0]      quot
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

[rtl/core/matrix_rotation_quaternion_extract_core.sv]
// ----------------------------------------------------------------------------
// matrix_rotation_quaternion_extract_core
// Polar decomposition of a Q8.24 3x3 matrix and rotation quaternion (Q2.30)
// extraction, run by a microcode sequencer over one multiplier, one
// divider and one square-root unit.
// ----------------------------------------------------------------------------
//  channel  | dir | payload (lowest bit first)
//  s_axis   | in  | tdata m00..m22 (9 x 32), tuser already_orthogonal
//  m_axis   | out | tdata quat_w, quat_x, quat_y, quat_z, tuser singular, steps_used
//  cfg      | in  | index 0 converge_threshold, 1 max_iterations
//
//  The restoring divider (nine times per step, four times at the end when
//  the norm is not zero) and the square-root unit dominate the run time.
//  One item is in work at a time; a finished result waits in the output
//  register while the next item is taken, and a result still held when the
//  next one is ready stalls the sequencer.
//  Reset clears the sequencer and the output valid and loads the config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_rotation_quaternion_extract_core
    import mrqe_pkg::*;
#(
    parameter int ITER_LIMIT = 10
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [287:0] s_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  wire logic         s_axis_tuser,   // already_orthogonal
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic [4:0]        m_axis_tuser,   // singular, steps_used
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_MAXIT  = 1'b1;

    logic [31:0]       thr_reg;
    logic [3:0]        maxit_reg;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [3:0]        idx_reg, idx_next;
    logic              out_valid_reg;
    ucw_t              cw;

    logic signed [31:0] mem_reg [MEM_DEPTH];
    logic signed [31:0] in_reg  [9];
    logic signed [31:0] opa_reg, opb_reg;
    logic signed [63:0] prod_reg, acc_reg, den_reg;
    logic [3:0]         lim_reg, steps_reg;
    logic               singular_reg, qneg_reg;
    logic signed [31:0] d0_reg, d1_reg, d2_reg;
    logic [3:0]         neg_reg;
    logic [31:0]        mag_reg [4];
    logic signed [31:0] qout_reg [4];
    logic [63:0]        sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [127:0]       out_data_reg;
    logic [4:0]         out_user_reg;

    addr_t              ra, rb;
    rd_pair_t           cp;
    logic               div_start, div_busy;
    logic [DIV_W-1:0]   div_num, div_den, div_quot;
    logic signed [63:0] prod_sh, cof_t, q_sig, opb_w;
    logic signed [31:0] nv, dlt;
    logic signed [35:0] dsum;
    logic [35:0]        dsum_abs;
    logic [31:0]        s_abs;
    logic [63:0]        den_abs, sq_sum;
    logic               unit_done, br, out_free;
    logic [3:0]         lim_cfg;

    assign cw       = ucode(pc_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign lim_cfg  = (maxit_reg < 4'(ITER_LIMIT)) ? maxit_reg : 4'(ITER_LIMIT);

    always_comb
    begin
        cp = cof_addr(idx_reg, cw.uop == U_CF_L2);
        ra = cp.ra;
        rb = cp.rb;
        case (cw.uop)
            U_DT_F:  begin ra = 5'(idx_reg * 3); rb = 5'(S_BASE + idx_reg * 3); end
            U_UP_F:  begin ra = 5'(S_BASE + idx_reg); rb = 5'(idx_reg); end
            U_QF_0:  begin ra = 5'd0; rb = 5'd4; end
            U_QF_1:  begin ra = 5'd8; rb = 5'd8; end
            U_QF_2:  begin ra = 5'd5; rb = 5'd7; end
            U_QF_3:  begin ra = 5'd6; rb = 5'd2; end
            U_QF_4:  begin ra = 5'd1; rb = 5'd3; end
            default: ;
        endcase
    end

    always_comb
    begin
        prod_sh = prod_reg >>> 24;
        cof_t   = acc_reg - prod_sh;
        if (idx_reg[0])
            cof_t = -cof_t;
        opb_w   = 64'(opb_reg);
        q_sig   = qneg_reg ? -$signed({4'b0, div_quot}) : $signed({4'b0, div_quot});
        nv      = sat32(q_sig + (opb_w >>> 1));
        dlt     = sat32(64'(nv) - opb_w);
        s_abs   = opa_reg[31] ? 32'(-$signed({1'b1, opa_reg})) : opa_reg;
        den_abs = den_reg[63] ? 64'(-den_reg) : 64'(den_reg);
        case (idx_reg[1:0])
            2'd0:    dsum = 36'sd16777216 + 36'(d0_reg) + 36'(d1_reg) + 36'(d2_reg);
            2'd1:    dsum = 36'sd16777216 + 36'(d0_reg) - 36'(d1_reg) - 36'(d2_reg);
            2'd2:    dsum = 36'sd16777216 - 36'(d0_reg) + 36'(d1_reg) - 36'(d2_reg);
            default: dsum = 36'sd16777216 - 36'(d0_reg) - 36'(d1_reg) + 36'(d2_reg);
        endcase
        dsum_abs = dsum[35] ? 36'(-dsum) : 36'(dsum);
        sq_sum   = sq_r_reg + sq_bit_reg;
    end

    assign div_start = (cw.uop == U_UP_GO) || (cw.uop == U_QD_GO);
    assign div_num   = (cw.uop == U_UP_GO) ? {4'b0, s_abs, 24'b0}
                                          : {mag_reg[idx_reg[1:0]][29:0], 30'b0};
    assign div_den   = (cw.uop == U_UP_GO) ? den_abs[DIV_W-1:0]
                                          : {28'b0, sq_r_reg[31:0]};

    mrqe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (cw.uop == U_UP_WAIT || cw.uop == U_QD_WAIT)
            unit_done = !div_busy;
        else
            unit_done = (sq_bit_reg == 64'd0);
        case (cw.uop)
            U_START:  br = (lim_reg == 4'd0);
            U_DT_CHK: br = (acc_reg == 64'sd0);
            U_IT_END: br = !(acc_reg < $signed({32'b0, thr_reg})) && (steps_reg != lim_reg);
            U_QN_CHK: br = (sq_r_reg == 64'd0);
            default:  br = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next  = pc_reg;
        idx_next = idx_reg;
        case (cw.kind)
            K_NEXT:    pc_next = pc_reg + 1'b1;
            K_LOOP:
            begin
                if (idx_reg == cw.last)
                begin
                    idx_next = '0;
                    pc_next  = pc_reg + 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    pc_next  = cw.tgt;
                end
            end
            K_WAIT_IN: if (s_axis_tvalid) pc_next = pc_reg + 1'b1;
            K_WAIT_U:  if (unit_done) pc_next = pc_reg + 1'b1;
            K_BRANCH:  pc_next = br ? cw.tgt : pc_reg + 1'b1;
            K_OUT:     if (out_free) pc_next = cw.tgt;
            default:   pc_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= 32'd17;
            maxit_reg     <= 4'd10;
        end
        else
        begin
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
            if (cw.uop == U_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == CFG_THRESH)
                thr_reg <= cfg_wdata;
            if (cfg_we && cfg_index == CFG_MAXIT)
                maxit_reg <= cfg_wdata[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cw.uop)
            U_UP_GO, U_UP_WAIT: opa_reg <= mem_reg[ra];
            U_UP_WR:
            begin
                opa_reg <= dlt;
                opb_reg <= dlt;
            end
            U_QS_ST:
            begin
                opa_reg <= sq_r_reg[31:0];
                opb_reg <= sq_r_reg[31:0];
            end
            default:
            begin
                opa_reg <= mem_reg[ra];
                opb_reg <= mem_reg[rb];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cw.uop)
            U_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    for (int k = 0; k < 9; k++)
                        in_reg[k] <= s_axis_tdata[k*32 +: 32];
                    lim_reg      <= s_axis_tuser ? 4'd0 : lim_cfg;
                    steps_reg    <= '0;
                    singular_reg <= 1'b0;
                end
            end
            U_LOAD:   mem_reg[5'(idx_reg)] <= in_reg[idx_reg];
            U_MUL:    prod_reg <= opa_reg * opb_reg;
            U_CF_L2:  acc_reg <= prod_sh;
            U_CF_WR:  mem_reg[5'(S_BASE + idx_reg)] <= sat32(cof_t);
            U_DT_ACC: acc_reg <= ((idx_reg == 4'd0) ? 64'sd0 : acc_reg) + prod_sh;
            U_DT_CHK:
            begin
                if (acc_reg == 64'sd0)
                    singular_reg <= 1'b1;
                else
                    steps_reg <= steps_reg + 1'b1;
                den_reg <= acc_reg <<< 1;
            end
            U_UP_GO:  qneg_reg <= opa_reg[31] ^ den_reg[63];
            U_UP_WR:  mem_reg[5'(idx_reg)] <= nv;
            U_UP_ACC: acc_reg <= ((idx_reg == 4'd0) ? 64'sd0 : acc_reg) + prod_sh;
            U_QF_1:
            begin
                d0_reg <= opa_reg;
                d1_reg <= opb_reg;
            end
            U_QF_2:   d2_reg <= opa_reg;
            U_QF_3:   neg_reg <= {2'b00, opa_reg < opb_reg, 1'b0};
            U_QF_4:   neg_reg[2] <= opa_reg < opb_reg;
            U_QF_5:   neg_reg[3] <= opa_reg < opb_reg;
            U_QS_ST:  mag_reg[idx_reg[1:0]] <= sq_r_reg[31:0];
            U_QS_ACC: acc_reg <= ((idx_reg == 4'd0) ? 64'sd0 : acc_reg) + prod_reg;
            U_QN_CHK:
            begin
                if (sq_r_reg == 64'd0)
                begin
                    qout_reg[0] <= 32'sh40000000;
                    qout_reg[1] <= '0;
                    qout_reg[2] <= '0;
                    qout_reg[3] <= '0;
                end
            end
            U_QD_ST:
                qout_reg[idx_reg[1:0]] <= neg_reg[idx_reg[1:0]]
                                          ? -$signed(div_quot[31:0]) : $signed(div_quot[31:0]);
            U_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg <= {qout_reg[3], qout_reg[2], qout_reg[1], qout_reg[0]};
                    out_user_reg <= {steps_reg, singular_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cw.uop == U_QS_GO || cw.uop == U_QN_GO)
        begin
            sq_v_reg   <= (cw.uop == U_QS_GO) ? {4'b0, dsum_abs, 24'b0} : 64'(acc_reg);
            sq_r_reg   <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (sq_bit_reg != 64'd0)
        begin
            if (sq_v_reg >= sq_sum)
            begin
                sq_v_reg <= sq_v_reg - sq_sum;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
                sq_r_reg <= sq_r_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    assign s_axis_tready = (cw.uop == U_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotation quaternion extraction core: a directed
// table followed by random matrices, checked against a predictor of the
// polar decomposition and quaternion arithmetic, with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int ITER_MAX  = 10;
    localparam int N_RANDOM  = 430;
    localparam int MAX_CYCLES = 20000000;
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_ITER  = 1'b1;
    localparam logic signed [31:0] Q24 = 32'sh01000000;
    localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] w, x, y, z;
        logic               singular;
        logic [3:0]         steps;
    } quat_res_t;

    typedef logic signed [31:0] mat_t [9];

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [287:0]   s_axis_tdata;
    logic           s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [127:0]   m_axis_tdata;
    logic [4:0]     m_axis_tuser;
    logic           cfg_we;
    logic           cfg_index;
    logic [31:0]    cfg_wdata;

    logic [31:0] thr_shadow;
    logic [3:0]  iter_shadow;
    quat_res_t   quat_queue[$];
    int          errors;
    int          cycles;
    int          out_wait;

    matrix_rotation_quaternion_extract_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic quat_res_t predict_quat(mat_t m, logic ortho);
        longint a[3][3], s[3][3], nm[3][3];
        longint det, den, sum, t, qv, nv, d, ds[4];
        longint unsigned mag[4], mg, n2, nrm;
        int lim, c, r, c1, c2, r1, r2, k;
        quat_res_t res;
        res = '0;
        for (c = 0; c < 3; c++)
            for (r = 0; r < 3; r++)
                a[c][r] = m[c*3+r];
        lim = (iter_shadow < ITER_MAX) ? iter_shadow : ITER_MAX;
        if (ortho)
            lim = 0;
        for (int i = 0; i < lim; i++)
        begin
            det = 0;
            sum = 0;
            for (c = 0; c < 3; c++)
            begin
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                for (r = 0; r < 3; r++)
                begin
                    r1 = (r == 0) ? 1 : 0;
                    r2 = (r == 2) ? 1 : 2;
                    t = fshr(a[c1][r1] * a[c2][r2], 24) - fshr(a[c2][r1] * a[c1][r2], 24);
                    if ((c + r) % 2 == 1)
                        t = -t;
                    s[c][r] = clamp32(t);
                end
            end
            for (c = 0; c < 3; c++)
                det += fshr(a[c][0] * s[c][0], 24);
            if (det == 0)
            begin
                res.singular = 1'b1;
                break;
            end
            res.steps++;
            den = 2 * det;
            for (c = 0; c < 3; c++)
                for (r = 0; r < 3; r++)
                begin
                    qv = (s[c][r] * 64'sd16777216) / den;
                    nv = clamp32(qv + fshr(a[c][r], 1));
                    d = clamp32(nv - a[c][r]);
                    mg = (d < 0) ? -d : d;
                    sum += longint'((mg * mg) >> 24);
                    nm[c][r] = nv;
                end
            a = nm;
            if (sum < longint'(thr_shadow))
                break;
        end
        ds[0] = 64'sd16777216 + a[0][0] + a[1][1] + a[2][2];
        ds[1] = 64'sd16777216 + a[0][0] - a[1][1] - a[2][2];
        ds[2] = 64'sd16777216 - a[0][0] + a[1][1] - a[2][2];
        ds[3] = 64'sd16777216 - a[0][0] - a[1][1] + a[2][2];
        n2 = 0;
        for (k = 0; k < 4; k++)
        begin
            mg = (ds[k] < 0) ? -ds[k] : ds[k];
            mag[k] = root64(mg << 24);
            n2 += mag[k] * mag[k];
        end
        nrm = root64(n2);
        if (nrm == 0)
        begin
            res.w = 32'sh40000000;
            res.x = 0;
            res.y = 0;
            res.z = 0;
        end
        else
        begin
            res.w = 32'((mag[0] << 30) / nrm);
            res.x = 32'((mag[1] << 30) / nrm);
            res.y = 32'((mag[2] << 30) / nrm);
            res.z = 32'((mag[3] << 30) / nrm);
            if (a[1][2] < a[2][1])
                res.x = -res.x;
            if (a[2][0] < a[0][2])
                res.y = -res.y;
            if (a[0][1] < a[1][0])
                res.z = -res.z;
        end
        return res;
    endfunction

    task automatic send_item(mat_t m, logic ortho, quat_res_t want);
        logic [287:0] packed_m;
        int gap;
        gap = $urandom_range(0, 13);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        for (int e = 0; e < 9; e++)
            packed_m[e*32 +: 32] = m[e];
        s_axis_tdata  <= packed_m;
        s_axis_tuser  <= ortho;
        s_axis_tvalid <= 1'b1;
        quat_queue.push_back(want);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_matrix(mat_t m, logic ortho);
        send_item(m, ortho, predict_quat(m, ortho));
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (quat_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thr_shadow = val;
        else
            iter_shadow = val[3:0];
    endtask

    // result side: random wait before each transaction
    always @(posedge clk or negedge rst_n)
    begin
        quat_res_t got, want;
        int draw;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_wait      <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[4:1]};
            if (quat_queue.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
            end
            else
            begin
                want = quat_queue.pop_front();
                if (got.w != want.w)
                begin
                    $error("quat_w expected %0d got %0d", want.w, got.w);
                    errors++;
                end
                if (got.x != want.x)
                begin
                    $error("quat_x expected %0d got %0d", want.x, got.x);
                    errors++;
                end
                if (got.y != want.y)
                begin
                    $error("quat_y expected %0d got %0d", want.y, got.y);
                    errors++;
                end
                if (got.z != want.z)
                begin
                    $error("quat_z expected %0d got %0d", want.z, got.z);
                    errors++;
                end
                if (got.singular != want.singular)
                begin
                    $error("singular expected %0d got %0d", want.singular, got.singular);
                    errors++;
                end
                if (got.steps != want.steps)
                begin
                    $error("steps_used expected %0d got %0d", want.steps, got.steps);
                    errors++;
                end
            end
            draw = $urandom_range(0, 13);
            out_wait      <= draw;
            m_axis_tready <= (draw == 0);
        end
        else if (out_wait != 0)
        begin
            out_wait      <= out_wait - 1;
            m_axis_tready <= (out_wait == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic signed [31:0] rand_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return QMAX;
            2: return QMIN;
            default: return $signed($urandom_range(0, 32'h03000000)) - 32'sh01800000;
        endcase
    endfunction

    initial
    begin
        mat_t      dm [14];
        logic      dortho [14];
        quat_res_t dexp [14];
        bit        dknown [14];
        mat_t      m;
        mat_t      ident;
        logic      ortho;
        int        kind;
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_wdata = '0;
        thr_shadow = 32'd17;
        iter_shadow = 4'd10;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 14; i++)
        begin
            dknown[i] = 1'b0;
            dexp[i]   = '0;
        end
        ident = '{Q24, 0, 0, 0, Q24, 0, 0, 0, Q24};
        dm[0]  = ident;                                  dortho[0]  = 1'b1;
        dm[1]  = ident;                                  dortho[1]  = 1'b0;
        dm[2]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0};           dortho[2]  = 1'b0;
        dm[3]  = '{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX}; dortho[3] = 1'b0;
        dm[4]  = '{QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN}; dortho[4] = 1'b0;
        dm[5]  = '{QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX}; dortho[5] = 1'b1;
        dm[6]  = '{0, Q24, 0, -Q24, 0, 0, 0, 0, Q24};    dortho[6]  = 1'b0;
        dm[7]  = '{2*Q24, 0, 0, 0, 3*Q24, 0, 0, 0, Q24/2}; dortho[7] = 1'b0;
        dm[8]  = '{-Q24, 0, 0, 0, -Q24, 0, 0, 0, Q24};   dortho[8]  = 1'b0;
        dm[9]  = '{Q24, 0, 0, 0, 0, Q24, 0, -Q24, 0};    dortho[9]  = 1'b1;
        dm[10] = '{Q24, Q24, 0, Q24, Q24, 0, 0, 0, Q24}; dortho[10] = 1'b0;
        dm[11] = '{Q24, 1, 0, 0, Q24, 0, 0, 0, Q24};     dortho[11] = 1'b0;
        dm[12] = '{0, 0, Q24, 0, Q24, 0, -Q24, 0, 0};    dortho[12] = 1'b0;
        dm[13] = '{-Q24, 0, 0, 0, Q24, 0, 0, 0, -Q24};   dortho[13] = 1'b1;
        dexp[0]  = '{32'sh40000000, 32'sd0, 32'sd0, 32'sd0, 1'b0, 4'd0};
        dknown[0] = 1'b1;
        dexp[1]  = '{32'sh40000000, 32'sd0, 32'sd0, 32'sd0, 1'b0, 4'd1};
        dknown[1] = 1'b1;
        dexp[2]  = '{32'sh20000000, 32'sh20000000, 32'sh20000000, 32'sh20000000, 1'b1, 4'd0};
        dknown[2] = 1'b1;
        dexp[13] = '{32'sd0, 32'sd0, 32'sh40000000, 32'sd0, 1'b0, 4'd0};
        dknown[13] = 1'b1;
        for (int i = 0; i < 14; i++)
        begin
            if (dknown[i])
                send_item(dm[i], dortho[i], dexp[i]);
            else
                send_matrix(dm[i], dortho[i]);
        end

        write_reg(CFG_MAX_ITER, 32'd15);
        write_reg(CFG_THRESHOLD, 32'd0);
        send_matrix('{2*Q24, Q24/3, 0, -Q24/5, Q24, 0, 7, 0, Q24}, 1'b0);
        write_reg(CFG_THRESHOLD, 32'hFFFFFFFF);
        send_matrix('{2*Q24, Q24/3, 0, -Q24/5, Q24, 0, 7, 0, Q24}, 1'b0);
        write_reg(CFG_MAX_ITER, 32'd0);
        send_matrix('{2*Q24, Q24/3, 0, -Q24/5, Q24, 0, 7, 0, Q24}, 1'b0);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_MAX_ITER, 32'd10); write_reg(CFG_THRESHOLD, 32'd17); end
                1: begin write_reg(CFG_MAX_ITER, 32'd1);  write_reg(CFG_THRESHOLD, 32'd0); end
                2: begin write_reg(CFG_MAX_ITER, 32'd15); write_reg(CFG_THRESHOLD, $urandom()); end
                3: begin write_reg(CFG_MAX_ITER, 32'd3);  write_reg(CFG_THRESHOLD, 32'd1000); end
                default: begin write_reg(CFG_MAX_ITER, 32'd0); end
            endcase
            for (int n = 0; n < N_RANDOM / 5; n++)
            begin
                kind = $urandom_range(0, 9);
                for (int e = 0; e < 9; e++)
                begin
                    if (kind < 6)
                        m[e] = ((e % 4) == 0 ? Q24 : 0) + rand_elem(3) / 8;
                    else if (kind < 8)
                        m[e] = rand_elem(3);
                    else
                        m[e] = rand_elem($urandom_range(0, 2));
                end
                ortho = ($urandom_range(0, 5) == 0);
                send_matrix(m, ortho);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (quat_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
